FILE: hw/rtl/bf_pkg.sv
// Package for the Blowfish block engine: sizes, item kinds, controller states
// and the memory write struct. No dependencies.
package bf_pkg;

   localparam int ROUNDS       = 16;
   localparam int WORD_W       = 32;
   localparam int KEY_DEPTH    = 18;
   localparam int KEY_AW       = $clog2(KEY_DEPTH);
   localparam int SBOX_BANKS   = 4;
   localparam int SBOX_ENTRIES = 256;
   localparam int SBOX_AW      = $clog2(SBOX_ENTRIES);
   localparam int TABLE_AW     = $clog2(SBOX_BANKS * SBOX_ENTRIES);
   localparam int BYTE_W       = 8;

   typedef enum logic [1:0] {
      KIND_LOAD_KEY  = 2'd0,
      KIND_LOAD_SBOX = 2'd1,
      KIND_ENCRYPT   = 2'd2,
      KIND_DECRYPT   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_ROUND,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                en;
      logic [TABLE_AW-1:0] addr;
      logic [WORD_W-1:0]   data;
   } mem_wr_type;

   // Subkey index for key step j: forward j, backward ROUNDS+1-j.
   function automatic logic [KEY_AW-1:0] key_index(input logic [KEY_AW-1:0] step,
                                                    input logic backward);
      logic [KEY_AW-1:0] idx;
      idx = backward ? (KEY_AW'(ROUNDS + 1) - step) : step;
      return idx;
   endfunction

endpackage

FILE: hw/rtl/bf_channels.sv
// Handshake channels of the Blowfish engine: request and response items.
// Widths taken from bf_pkg.
interface bf_req_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     kind;
   logic [bf_pkg::TABLE_AW-1:0]    table_index;
   logic [bf_pkg::WORD_W-1:0]      table_word;
   logic [bf_pkg::WORD_W-1:0]      block_left;
   logic [bf_pkg::WORD_W-1:0]      block_right;
   logic                           block_last;

   modport source (output valid, kind, table_index, table_word, block_left, block_right,
                   block_last, input ready);
   modport sink   (input valid, kind, table_index, table_word, block_left, block_right,
                   block_last, output ready);
endinterface

interface bf_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [bf_pkg::WORD_W-1:0] result_left;
   logic [bf_pkg::WORD_W-1:0] result_right;
   logic                      result_last;

   modport source (output valid, result_left, result_right, result_last, input ready);
   modport sink   (input valid, result_left, result_right, result_last, output ready);
endinterface

FILE: hw/rtl/bf_key_mem.sv
// Subkey store: 18 words, one write port, one registered read port.
// Depends on bf_pkg.
module bf_key_mem (
   input  logic                      clock,
   input  bf_pkg::mem_wr_type        wr,
   input  logic [bf_pkg::KEY_AW-1:0] rd_addr,
   output logic [bf_pkg::WORD_W-1:0] rd_data
);

   logic [bf_pkg::WORD_W-1:0] key_mem [bf_pkg::KEY_DEPTH];
   logic [bf_pkg::WORD_W-1:0] rd_q_ff;

   // writes beyond the last subkey are dropped
   always_ff @(posedge clock) begin
      if (wr.en && (wr.addr < bf_pkg::TABLE_AW'(bf_pkg::KEY_DEPTH))) begin
         key_mem[wr.addr[bf_pkg::KEY_AW-1:0]] <= wr.data;
      end
      rd_q_ff <= key_mem[rd_addr];
   end

   assign rd_data = rd_q_ff;

endmodule

FILE: hw/rtl/bf_sbox_mem.sv
// Four S-box banks, 256 words each, with the round function on their outputs.
// Depends on bf_pkg.
module bf_sbox_mem (
   input  logic                      clock,
   input  bf_pkg::mem_wr_type        wr,
   input  logic [bf_pkg::WORD_W-1:0] rd_word,
   output logic [bf_pkg::WORD_W-1:0] f_word
);

   logic [bf_pkg::WORD_W-1:0] rd_q_ff [bf_pkg::SBOX_BANKS];

   for (genvar b = 0; b < bf_pkg::SBOX_BANKS; b++) begin : g_bank
      logic [bf_pkg::WORD_W-1:0]  bank_mem [bf_pkg::SBOX_ENTRIES];
      logic [bf_pkg::SBOX_AW-1:0] rd_addr;

      // bank 0 is addressed by the most significant byte
      assign rd_addr = rd_word[(bf_pkg::SBOX_BANKS-1-b)*bf_pkg::BYTE_W +: bf_pkg::BYTE_W];

      always_ff @(posedge clock) begin
         if (wr.en && (wr.addr[bf_pkg::TABLE_AW-1:bf_pkg::SBOX_AW] ==
                       (bf_pkg::TABLE_AW-bf_pkg::SBOX_AW)'(b))) begin
            bank_mem[wr.addr[bf_pkg::SBOX_AW-1:0]] <= wr.data;
         end
         rd_q_ff[b] <= bank_mem[rd_addr];
      end
   end

   // F = ((S0 + S1) ^ S2) + S3, sums modulo 2^32
   assign f_word = ((rd_q_ff[0] + rd_q_ff[1]) ^ rd_q_ff[2]) + rd_q_ff[3];

endmodule

FILE: hw/rtl/blowfish_block_cipher_unit.sv
// Blowfish block engine top level: controller, half-block registers, output item register.
// Depends on bf_pkg, bf_channels (bf_req_if, bf_rsp_if), bf_key_mem and bf_sbox_mem.
//
// A load item (subkey or S-box word) goes straight into its memory and gives no
// result; a subkey load with an index above 17 is dropped. An encrypt or decrypt item
// steps through the states until its result is registered: ST_START applies the first
// subkey and starts the S-box reads, ST_ROUND runs the Feistel rounds, each reading
// the four registered S-box banks once, and ST_FINISH applies the closing subkey,
// waiting while the output register holds an unaccepted result. Requests are taken only
// while no block is in flight; a finished result sits in the output register, so
// the next item can be taken while that result waits. Memories have no reset:
// subkeys and S-boxes must be loaded before the first block.
module blowfish_block_cipher_unit (
   input  logic      clock,
   input  logic      reset,
   bf_req_if.sink    req_chan,
   bf_rsp_if.source  rsp_chan
);

   // control state
   bf_pkg::state_type          state_ff, state_in;
   logic [bf_pkg::KEY_AW-1:0]  step_ff, step_in;     // next subkey step to read
   logic                       rsp_valid_ff, rsp_valid_in;

   // payload
   logic [bf_pkg::WORD_W-1:0]  l_ff, l_in;
   logic [bf_pkg::WORD_W-1:0]  r_ff, r_in;
   logic                       dec_ff, dec_in;
   logic                       last_ff, last_in;
   logic [bf_pkg::WORD_W-1:0]  rsp_left_ff, rsp_right_ff;
   logic                       rsp_last_ff;

   // datapath
   logic                       req_fire;
   logic                       block_fire;
   logic                       req_is_decrypt;
   logic                       rsp_load;
   logic [bf_pkg::KEY_AW-1:0]  key_step;
   logic                       key_bwd;
   logic [bf_pkg::KEY_AW-1:0]  key_rd_addr;
   logic [bf_pkg::WORD_W-1:0]  key_q;
   logic [bf_pkg::WORD_W-1:0]  sbox_rd_word;
   logic [bf_pkg::WORD_W-1:0]  f_word;
   logic [bf_pkg::WORD_W-1:0]  mixed_r;
   bf_pkg::mem_wr_type         key_wr;
   bf_pkg::mem_wr_type         sbox_wr;
   bf_pkg::kind_type           req_kind;

   assign req_kind       = bf_pkg::kind_type'(req_chan.kind);
   assign req_chan.ready = (state_ff == bf_pkg::ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign block_fire     = req_fire && ((req_kind == bf_pkg::KIND_ENCRYPT) ||
                                        (req_kind == bf_pkg::KIND_DECRYPT));
   assign req_is_decrypt = (req_kind == bf_pkg::KIND_DECRYPT);

   // Load items go straight into the memories; only taken in idle, so no read
   // of a block in flight can see a write.
   always_comb begin
      key_wr.en    = req_fire && (req_kind == bf_pkg::KIND_LOAD_KEY);
      key_wr.addr  = req_chan.table_index;
      key_wr.data  = req_chan.table_word;
      sbox_wr.en   = req_fire && (req_kind == bf_pkg::KIND_LOAD_SBOX);
      sbox_wr.addr = req_chan.table_index;
      sbox_wr.data = req_chan.table_word;
   end

   // Subkey sequence: step j reads P[j] forward, P[ROUNDS+1-j] backward.
   // Reads run one step ahead so the word is in key_q when needed.
   assign key_rd_addr = bf_pkg::key_index(key_step, key_bwd);

   bf_key_mem u_key_mem (
      .clock   (clock),
      .wr      (key_wr),
      .rd_addr (key_rd_addr),
      .rd_data (key_q)
   );

   bf_sbox_mem u_sbox_mem (
      .clock   (clock),
      .wr      (sbox_wr),
      .rd_word (sbox_rd_word),
      .f_word  (f_word)
   );

   assign mixed_r = r_ff ^ f_word;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bf_pkg::ST_IDLE:   if (block_fire) state_in = bf_pkg::ST_START;
         bf_pkg::ST_START:  state_in = bf_pkg::ST_ROUND;
         bf_pkg::ST_ROUND: begin
            if (step_ff == bf_pkg::KEY_AW'(bf_pkg::ROUNDS + 1)) state_in = bf_pkg::ST_FINISH;
         end
         bf_pkg::ST_FINISH: if (rsp_load) state_in = bf_pkg::ST_IDLE;
         default:           state_in = bf_pkg::ST_IDLE;
      endcase
   end

   // datapath control
   // Round: l' = (r ^ F(l)) ^ next subkey, r' = l. After the last round l holds
   // the right result (already whitened), r the left one before its subkey.
   always_comb begin
      l_in         = l_ff;
      r_in         = r_ff;
      dec_in       = dec_ff;
      last_in      = last_ff;
      step_in      = step_ff;
      key_step     = step_ff;
      key_bwd      = dec_ff;
      sbox_rd_word = l_ff ^ key_q;
      rsp_load     = 1'b0;
      unique case (state_ff)
         bf_pkg::ST_IDLE: begin
            key_step = '0;
            key_bwd  = req_is_decrypt;
            if (block_fire) begin
               l_in    = req_chan.block_left;
               r_in    = req_chan.block_right;
               dec_in  = req_is_decrypt;
               last_in = req_chan.block_last;
               step_in = bf_pkg::KEY_AW'(1);
            end
         end
         bf_pkg::ST_START: begin
            l_in         = l_ff ^ key_q;
            sbox_rd_word = l_ff ^ key_q;
            step_in      = step_ff + bf_pkg::KEY_AW'(1);
         end
         bf_pkg::ST_ROUND: begin
            l_in         = mixed_r ^ key_q;
            r_in         = l_ff;
            sbox_rd_word = mixed_r ^ key_q;
            if (step_ff != bf_pkg::KEY_AW'(bf_pkg::ROUNDS + 1))
               step_in = step_ff + bf_pkg::KEY_AW'(1);
         end
         bf_pkg::ST_FINISH: begin
            rsp_load = !rsp_valid_ff || rsp_chan.ready;
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bf_pkg::ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      l_ff    <= l_in;
      r_ff    <= r_in;
      dec_ff  <= dec_in;
      last_ff <= last_in;
      if (rsp_load) begin
         rsp_left_ff  <= r_ff ^ key_q;
         rsp_right_ff <= l_ff;
         rsp_last_ff  <= last_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_left  = rsp_left_ff;
   assign rsp_chan.result_right = rsp_right_ff;
   assign rsp_chan.result_last  = rsp_last_ff;

   // checks
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= bf_pkg::KEY_AW'(bf_pkg::ROUNDS + 1))
      else $error("subkey step out of range");

   a_block_starts: assert property (@(posedge clock) disable iff (reset)
      block_fire |=> (state_ff == bf_pkg::ST_START))
      else $error("accepted block did not start");

   a_no_write_in_flight: assert property (@(posedge clock) disable iff (reset)
      (state_ff != bf_pkg::ST_IDLE) |-> (!key_wr.en && !sbox_wr.en))
      else $error("table write while a block is in flight");

   a_finish_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bf_pkg::ST_FINISH) && !rsp_valid_ff |=>
         rsp_valid_ff && (state_ff == bf_pkg::ST_IDLE))
      else $error("finished block not registered");

endmodule
